FILE: sv/tvdp_pkg.sv
// Package: widths, fixed-point constants and pipeline depth for the dual projection block.
`timescale 1ns / 1ps
package tvdp_pkg;
   localparam int FRAC_BITS = 16;
   localparam int W         = 24;
   localparam int SW        = 2 * W;                  // sum of three squares
   localparam int NW        = FRAC_BITS + 1;          // scaled magnitude, at most 1.0
   localparam int PW        = 2 * W + 2 * FRAC_BITS + 8;
   localparam int EW        = W + 2;                  // headroom for saturation
   localparam int STEPS     = FRAC_BITS + 1;
   // input reg, squares, sum, STEPS search stages, output reg
   localparam int LATENCY   = STEPS + 4;
   localparam logic [SW-1:0] ONE_SQ = SW'(1) << (2 * FRAC_BITS);
endpackage

FILE: sv/tv_dual_vector_projection.sv
// Top level: pipelined unit-ball or box projection of dual 3-vectors.
`timescale 1ns / 1ps
//  channel   | ports                              | handshake
//  request   | req_p_x/y/z, req_last_in           | start high, busy low
//  response  | rsp_q_x/y/z, rsp_last_out          | rsp_valid one cycle, no stall
//  csr       | csr_aniso_mode                     | csr_valid and csr_ready
// One vector enters per cycle; each result comes from a reciprocal-root
// search that resolves one result bit per pipeline stage. Components
// are signed Q8.16.
// Reset clears all valid bits and the mode register; busy is high only in reset.
// The response side never stalls, so the pipeline never holds.
module tv_dual_vector_projection (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [tvdp_pkg::W-1:0]  req_p_x,
   input  logic signed [tvdp_pkg::W-1:0]  req_p_y,
   input  logic signed [tvdp_pkg::W-1:0]  req_p_z,
   input  logic                           req_last_in,
   output logic                           rsp_valid,
   output logic signed [tvdp_pkg::W-1:0]  rsp_q_x,
   output logic signed [tvdp_pkg::W-1:0]  rsp_q_y,
   output logic signed [tvdp_pkg::W-1:0]  rsp_q_z,
   output logic                           rsp_last_out,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_aniso_mode
);
   localparam int W  = tvdp_pkg::W;
   localparam int F  = tvdp_pkg::FRAC_BITS;
   localparam int SW = tvdp_pkg::SW;
   localparam int NW = tvdp_pkg::NW;
   localparam int PW = tvdp_pkg::PW;
   localparam int EW = tvdp_pkg::EW;
   localparam int ST = tvdp_pkg::STEPS;

   logic accept;
   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   // mode register
   logic mode_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         mode_ff <= csr_aniso_mode;
      end
   end

   // stage A: input capture
   logic                va_ff;
   logic signed [W-1:0] pa_ff [3];
   logic                la_ff, ma_ff;
   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else       va_ff <= accept;
      pa_ff[0] <= req_p_x;
      pa_ff[1] <= req_p_y;
      pa_ff[2] <= req_p_z;
      la_ff    <= req_last_in;
      ma_ff    <= mode_ff;
   end

   // stage B: squares of magnitudes
   logic                vb_ff, lb_ff, mb_ff;
   logic signed [W-1:0] pb_ff [3];
   logic [SW-1:0]       sqb_ff [3];
   logic [W-1:0]        mag_a [3];
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mag_a[c] = pa_ff[c][W-1] ? W'(-pa_ff[c]) : W'(pa_ff[c]);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else       vb_ff <= va_ff;
      lb_ff <= la_ff;
      mb_ff <= ma_ff;
      for (int c = 0; c < 3; c++) begin
         pb_ff[c]  <= pa_ff[c];
         sqb_ff[c] <= SW'(mag_a[c] * mag_a[c]);
      end
   end

   // stage C: sum of squares, threshold, per-component bound
   logic                vc_ff, lc_ff, mc_ff, bigc_ff;
   logic signed [W-1:0] pc_ff [3];
   logic [SW-1:0]       sc_ff;
   logic [SW-1:0]       rc_ff [3];
   logic [SW-1:0]       sum_b;
   assign sum_b = sqb_ff[0] + sqb_ff[1] + sqb_ff[2];
   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else       vc_ff <= vb_ff;
      lc_ff   <= lb_ff;
      mc_ff   <= mb_ff;
      sc_ff   <= sum_b;
      bigc_ff <= sum_b > tvdp_pkg::ONE_SQ;
      for (int c = 0; c < 3; c++) begin
         pc_ff[c] <= pb_ff[c];
         rc_ff[c] <= sqb_ff[c];
      end
   end

   // search stages: largest n with (2n-1)^2 s <= a^2 2^(2F+2),
   // tracking P = (2n-1)^2 s and Q = (2n-1) s with adds only
   logic                 vi_ff [ST];
   logic                 li_ff [ST];
   logic                 mi_ff [ST];
   logic                 bigi_ff [ST];
   logic signed [W-1:0]  pi_ff [ST][3];
   logic [SW-1:0]        si_ff [ST];
   logic [SW-1:0]        ri_ff [ST][3];
   logic [NW-1:0]        ni_ff [ST][3];
   logic signed [PW-1:0] bp_ff [ST][3];
   logic signed [PW-1:0] bq_ff [ST][3];

   logic [NW-1:0]        n_in  [ST][3];
   logic signed [PW-1:0] p_in  [ST][3];
   logic signed [PW-1:0] q_in  [ST][3];

   always_comb begin
      logic [NW-1:0]        n_prev;
      logic signed [PW-1:0] p_prev, q_prev, s_ext, r_ext, cand;
      for (int j = 0; j < ST; j++) begin
         for (int c = 0; c < 3; c++) begin
            if (j == 0) begin
               s_ext  = signed'(PW'(sc_ff));
               r_ext  = signed'(PW'(rc_ff[c])) <<< (2 * F + 2);
               n_prev = '0;
               p_prev = s_ext;
               q_prev = -s_ext;
            end else begin
               s_ext  = signed'(PW'(si_ff[j-1]));
               r_ext  = signed'(PW'(ri_ff[j-1][c])) <<< (2 * F + 2);
               n_prev = ni_ff[j-1][c];
               p_prev = bp_ff[j-1][c];
               q_prev = bq_ff[j-1][c];
            end
            cand = p_prev + (q_prev <<< (F - j + 2)) + (s_ext <<< (2 * (F - j) + 2));
            if (cand <= r_ext) begin
               n_in[j][c] = n_prev | (NW'(1) << (F - j));
               p_in[j][c] = cand;
               q_in[j][c] = q_prev + (s_ext <<< (F - j + 1));
            end else begin
               n_in[j][c] = n_prev;
               p_in[j][c] = p_prev;
               q_in[j][c] = q_prev;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < ST; j++) begin
         if (reset) vi_ff[j] <= 1'b0;
         else       vi_ff[j] <= (j == 0) ? vc_ff : vi_ff[(j == 0) ? 0 : j - 1];
         li_ff[j]   <= (j == 0) ? lc_ff   : li_ff[(j == 0) ? 0 : j - 1];
         mi_ff[j]   <= (j == 0) ? mc_ff   : mi_ff[(j == 0) ? 0 : j - 1];
         bigi_ff[j] <= (j == 0) ? bigc_ff : bigi_ff[(j == 0) ? 0 : j - 1];
         si_ff[j]   <= (j == 0) ? sc_ff   : si_ff[(j == 0) ? 0 : j - 1];
         for (int c = 0; c < 3; c++) begin
            pi_ff[j][c] <= (j == 0) ? pc_ff[c] : pi_ff[(j == 0) ? 0 : j - 1][c];
            ri_ff[j][c] <= (j == 0) ? rc_ff[c] : ri_ff[(j == 0) ? 0 : j - 1][c];
            ni_ff[j][c] <= n_in[j][c];
            bp_ff[j][c] <= p_in[j][c];
            bq_ff[j][c] <= q_in[j][c];
         end
      end
   end

   // output stage: sign, clamp, saturate, mode select
   localparam logic signed [EW-1:0] MAXP = EW'((1 << (W - 1)) - 1);
   localparam logic signed [EW-1:0] MINN = -(EW'(1) <<< (W - 1));
   localparam logic signed [EW-1:0] ONE  = EW'(1) <<< F;

   logic                rv_ff, rl_ff;
   logic signed [W-1:0] rq_ff [3];
   logic signed [W-1:0] q_in_out [3];
   always_comb begin
      logic signed [EW-1:0] pe, v;
      for (int c = 0; c < 3; c++) begin
         pe = EW'(pi_ff[ST-1][c]);
         if (mi_ff[ST-1]) begin
            v = (pe > ONE) ? ONE : ((pe < -ONE) ? -ONE : pe);
         end else if (bigi_ff[ST-1]) begin
            v = signed'(EW'(ni_ff[ST-1][c]));
            if (pe < 0) v = -v;
         end else begin
            v = pe;
         end
         if (v > MAXP)      v = MAXP;
         else if (v < MINN) v = MINN;
         q_in_out[c] = W'(v);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else       rv_ff <= vi_ff[ST-1];
      rl_ff <= li_ff[ST-1];
      for (int c = 0; c < 3; c++) rq_ff[c] <= q_in_out[c];
   end

   assign rsp_valid    = rv_ff;
   assign rsp_q_x      = rq_ff[0];
   assign rsp_q_y      = rq_ff[1];
   assign rsp_q_z      = rq_ff[2];
   assign rsp_last_out = rl_ff;
endmodule

FILE: sv/tvdp_checker.sv
// Port-level checks for the dual projection block, bound to the top level.
`timescale 1ns / 1ps
module tvdp_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last_in,
   input logic rsp_valid,
   input logic rsp_last_out
);
   localparam int L = tvdp_pkg::LATENCY;

   // every accepted transaction leaves after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##L rsp_valid)
      else $error("response missing after accepted transaction");

   // no response unless a transaction was accepted to match it
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##L !rsp_valid)
      else $error("response without transaction");

   // last flag follows its transaction
   a_last: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##L (rsp_last_out == $past(req_last_in, L)))
      else $error("last flag mismatch");

   // busy only during reset
   a_busy: assert property (@(posedge clock) !reset |-> !busy)
      else $error("busy outside reset");
endmodule

bind tv_dual_vector_projection tvdp_checker u_tvdp_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_last_in(req_last_in), .rsp_valid(rsp_valid), .rsp_last_out(rsp_last_out)
);
